// ===== src/ncon_pkg.sv =====
// Shared types, constants and helpers of the 3x3 neighbor contrast filter.
package ncon_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam logic [7:0]  NIBBLE_KEEP      = 8'hF0;
    localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Register index as decoded from paddr[2]
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef logic [3:0] nib_t;
    typedef nib_t [2:0] pix_t;   // one nibble per channel, channel 0 in [0]
    typedef pix_t [2:0] col_t;   // row 0 top, row 2 newest line
    typedef col_t [2:0] win_t;   // column 2 newest
    typedef nib_t [8:0] nbr_t;   // 3x3 neighborhood of one channel, center at [4]

    typedef struct packed {
        logic       cmd;
        logic [7:0] chan0;
        logic [7:0] chan1;
        logic [7:0] chan2;
    } pix_item_t;

    typedef struct packed {
        logic [7:0]  energy0;
        logic [7:0]  energy1;
        logic [7:0]  energy2;
        logic [11:0] out_row;
        logic [10:0] out_col;
        logic        frame_last;
    } res_item_t;

    function automatic pix_t pack_pixel(pix_item_t it);
        logic [7:0] m0;
        logic [7:0] m1;
        logic [7:0] m2;
        pix_t       p;
        m0 = it.chan0 & NIBBLE_KEEP;
        m1 = it.chan1 & NIBBLE_KEEP;
        m2 = it.chan2 & NIBBLE_KEEP;
        p[0] = m0[7:4];
        p[1] = m1[7:4];
        p[2] = m2[7:4];
        if (it.cmd == CMD_FLUSH)
        begin
            p = '0;
        end
        return p;
    endfunction

endpackage

// ===== src/ncon_lane.sv =====
// One channel lane: largest absolute difference between the center and its neighbors.
module ncon_lane
    import ncon_pkg::*;
(
    input  nbr_t       nbr,
    output logic [7:0] energy
);

    always_comb
    begin
        nib_t best;
        nib_t d;
        best = '0;
        for (int k = 0; k < 9; k++)
        begin
            d = (nbr[k] > nbr[4]) ? (nbr[k] - nbr[4]) : (nbr[4] - nbr[k]);
            if (d > best)
            begin
                best = d;
            end
        end
        // nibbles came from the upper half of each sample
        energy = {best, 4'b0000};
    end

endmodule

// ===== src/neighbor_contrast_3x3_top.sv =====
// Top level of the 3x3 neighbor contrast filter: counters, line store, window, lanes, output.
//
// Takes one pixel item per clock and gives one result item per clock, while the output side
// does not stall, once the first frame_width+1 items of a frame are in; a taken item moves
// through the s1, s2 and result registers in turn. The rate is set by the line store,
// which is read once and written once per item through its single read and single write
// port, with a bypass when an item reads the entry that the previous item is writing.
// Results come in raster order, frame_width+1 items behind the input; after the last
// pixel of a frame send frame_width+1 flush items to drain the final row. The result
// carrying frame_last closes the frame and the next item starts a new one. The line
// store is not cleared after reset; an entry that was never written never reaches a result.
module neighbor_contrast_3x3_top
    import ncon_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        pix_valid,
    output logic        pix_stall,
    input  pix_item_t   pix_data,
    output logic        res_valid,
    input  logic        res_stall,
    output res_item_t   res_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int CWC_W = (WID_W > 12) ? WID_W : 12;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
    localparam int CHC_W = (HGT_W > 13) ? HGT_W : 13;

    localparam logic [1:0] IN_ROW_FIRST  = 2'd0;
    localparam logic [1:0] IN_ROW_SECOND = 2'd1;
    localparam logic [1:0] IN_ROW_LATER  = 2'd2;

    typedef struct packed {
        pix_t center;
        pix_t above;
    } line_t;

    typedef struct packed {
        pix_t             pix;
        logic [COL_W-1:0] idx;
        logic             emit;
        logic             use_old;
        logic [1:0]       lsel;
        logic [1:0]       csel;
        logic [1:0]       rsel;
        logic [1:0]       tsel;
        logic [1:0]       bsel;
        logic [ROW_W-1:0] orow;
        logic [COL_W-1:0] ocol;
        logic             last;
    } s1_t;

    typedef struct packed {
        win_t             nb;
        logic [ROW_W-1:0] orow;
        logic [COL_W-1:0] ocol;
        logic             last;
    } s2_t;

    function automatic col_t pick_col(win_t b, logic [1:0] s);
        col_t c;
        case (s)
            2'd0:    c = b[0];
            2'd1:    c = b[1];
            default: c = b[2];
        endcase
        return c;
    endfunction

    function automatic pix_t pick_row(col_t c, logic [1:0] s);
        pix_t p;
        case (s)
            2'd0:    p = c[0];
            2'd1:    p = c[1];
            default: p = c[2];
        endcase
        return p;
    endfunction

    // Configuration registers
    logic [11:0] frame_width_reg;
    logic [12:0] frame_height_reg;
    logic        cfg_wr;

    // Position counters
    logic [COL_W-1:0] in_col_reg;
    logic [1:0]       in_row_reg;
    logic [COL_W-1:0] ocol_reg;
    logic [ROW_W-1:0] orow_reg;
    logic [COL_W-1:0] in_col_next;
    logic [1:0]       in_row_next;
    logic [COL_W-1:0] ocol_next;
    logic [ROW_W-1:0] orow_next;

    logic [WID_W-1:0] w_eff;
    logic [HGT_W-1:0] h_eff;
    logic [WID_W-1:0] in_col_inc;
    logic [WID_W-1:0] ocol_inc;
    logic [HGT_W-1:0] orow_inc;
    logic             col_wrap;
    logic             ocol_wrap;
    logic             orow_end;
    logic             emit;
    logic             frame_end;

    // Pipeline control
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic res_valid_reg;
    logic out_free;
    logic s2_adv;
    logic s2_free;
    logic s1_adv;
    logic s1_free;
    logic accept;

    s1_t       s1_reg;
    s1_t       s1_next;
    s2_t       s2_reg;
    s2_t       s2_next;
    res_item_t res_data_reg;

    // Line store and bypass
    line_t line_mem [MAX_WIDTH];
    line_t line_q_reg;
    line_t fwd_data_reg;
    logic  fwd_hit_reg;
    line_t line_rd;
    line_t line_wr;

    win_t window_reg;
    win_t window_next;
    win_t base;
    col_t new_col;

    logic [2:0][7:0] lane_energy;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[11:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[12:0];
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_FRAME_WIDTH:  prdata = 32'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = 32'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    // Clamp the frame size into 1..maximum
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_eff = WID_W'(1);
        end
        else if (CWC_W'(frame_width_reg) > CWC_W'(MAX_WIDTH))
        begin
            w_eff = WID_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WID_W'(frame_width_reg);
        end

        if (frame_height_reg == '0)
        begin
            h_eff = HGT_W'(1);
        end
        else if (CHC_W'(frame_height_reg) > CHC_W'(MAX_HEIGHT))
        begin
            h_eff = HGT_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HGT_W'(frame_height_reg);
        end
    end

    // ---------------- handshake ----------------
    assign out_free  = !res_valid_reg || !res_stall;
    assign s2_adv    = s2_valid_reg && out_free;
    assign s2_free   = !s2_valid_reg || out_free;
    assign s1_adv    = s1_valid_reg && (!s1_reg.emit || s2_free);
    assign s1_free   = !s1_valid_reg || s1_adv;
    assign accept    = pix_valid && s1_free;
    assign pix_stall = !s1_free;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // ---------------- position counters and per-item selection ----------------
    always_comb
    begin
        in_col_inc = WID_W'(in_col_reg) + WID_W'(1);
        ocol_inc   = WID_W'(ocol_reg) + WID_W'(1);
        orow_inc   = HGT_W'(orow_reg) + HGT_W'(1);
        col_wrap   = in_col_inc >= w_eff;
        ocol_wrap  = ocol_inc >= w_eff;
        orow_end   = orow_inc >= h_eff;
        emit       = (in_row_reg == IN_ROW_LATER)
                     || ((in_row_reg == IN_ROW_SECOND) && (in_col_reg != '0));
        frame_end  = orow_end && ocol_wrap;

        in_col_next = col_wrap ? '0 : COL_W'(in_col_inc);
        in_row_next = in_row_reg;
        if (col_wrap)
        begin
            case (in_row_reg)
                IN_ROW_FIRST:  in_row_next = IN_ROW_SECOND;
                IN_ROW_SECOND: in_row_next = IN_ROW_LATER;
                default:       in_row_next = IN_ROW_LATER;
            endcase
        end

        ocol_next = ocol_reg;
        orow_next = orow_reg;
        if (emit)
        begin
            ocol_next = ocol_wrap ? '0 : COL_W'(ocol_inc);
            if (ocol_wrap)
            begin
                orow_next = ROW_W'(orow_inc);
            end
            // close the frame: every counter back to the start
            if (frame_end)
            begin
                in_col_next = '0;
                in_row_next = IN_ROW_FIRST;
                ocol_next   = '0;
                orow_next   = '0;
            end
        end

        s1_next.pix     = pack_pixel(pix_data);
        s1_next.idx     = in_col_reg;
        s1_next.emit    = emit;
        s1_next.use_old = (in_col_reg == '0);
        if (in_col_reg == '0)
        begin
            // center is the previous item's column, right edge replicated
            s1_next.lsel = (ocol_reg == '0) ? 2'd2 : 2'd1;
            s1_next.csel = 2'd2;
            s1_next.rsel = 2'd2;
        end
        else
        begin
            s1_next.lsel = (ocol_reg == '0) ? 2'd1 : 2'd0;
            s1_next.csel = 2'd1;
            s1_next.rsel = ocol_wrap ? 2'd1 : 2'd2;
        end
        s1_next.tsel = (orow_reg == '0) ? 2'd1 : 2'd0;
        s1_next.bsel = orow_end ? 2'd1 : 2'd2;
        s1_next.orow = orow_reg;
        s1_next.ocol = ocol_reg;
        s1_next.last = frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= IN_ROW_FIRST;
            ocol_reg   <= '0;
            orow_reg   <= '0;
        end
        else if (accept)
        begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            ocol_reg   <= ocol_next;
            orow_reg   <= orow_next;
        end
    end

    // ---------------- line store ----------------
    assign line_rd = fwd_hit_reg ? fwd_data_reg : line_q_reg;

    always_comb
    begin
        line_wr.above  = line_rd.center;
        line_wr.center = s1_reg.pix;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            line_mem[s1_reg.idx] <= line_wr;
        end
        if (accept)
        begin
            line_q_reg <= line_mem[in_col_reg];
        end
    end

    // Bypass the entry that the item ahead writes in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (accept)
        begin
            fwd_hit_reg <= s1_valid_reg && (s1_reg.idx == in_col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_data_reg <= line_wr;
        end
    end

    // ---------------- window and neighborhood selection ----------------
    always_comb
    begin
        new_col[0] = line_rd.above;
        new_col[1] = line_rd.center;
        new_col[2] = s1_reg.pix;

        window_next[2] = new_col;
        window_next[1] = window_reg[2];
        window_next[0] = window_reg[1];

        base = s1_reg.use_old ? window_reg : window_next;

        s2_next.nb[0][0] = pick_row(pick_col(base, s1_reg.lsel), s1_reg.tsel);
        s2_next.nb[0][1] = pick_row(pick_col(base, s1_reg.lsel), 2'd1);
        s2_next.nb[0][2] = pick_row(pick_col(base, s1_reg.lsel), s1_reg.bsel);
        s2_next.nb[1][0] = pick_row(pick_col(base, s1_reg.csel), s1_reg.tsel);
        s2_next.nb[1][1] = pick_row(pick_col(base, s1_reg.csel), 2'd1);
        s2_next.nb[1][2] = pick_row(pick_col(base, s1_reg.csel), s1_reg.bsel);
        s2_next.nb[2][0] = pick_row(pick_col(base, s1_reg.rsel), s1_reg.tsel);
        s2_next.nb[2][1] = pick_row(pick_col(base, s1_reg.rsel), 2'd1);
        s2_next.nb[2][2] = pick_row(pick_col(base, s1_reg.rsel), s1_reg.bsel);
        s2_next.orow     = s1_reg.orow;
        s2_next.ocol     = s1_reg.ocol;
        s2_next.last     = s1_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (s1_adv)
        begin
            window_reg <= window_next;
        end
    end

    // ---------------- pipeline valids ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= pix_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_adv && s1_reg.emit;
            end
            if (out_free)
            begin
                res_valid_reg <= s2_valid_reg;
            end
        end
    end

    // ---------------- channel lanes and merge ----------------
    for (genvar ch = 0; ch < 3; ch++)
    begin : g_lane
        nbr_t nbr;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    nbr[i * 3 + j] = s2_reg.nb[i][j][ch];
                end
            end
        end

        ncon_lane u_lane
        (
            .nbr    (nbr),
            .energy (lane_energy[ch])
        );
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_adv && s1_reg.emit)
        begin
            s2_reg <= s2_next;
        end
        if (s2_adv)
        begin
            res_data_reg.energy0    <= lane_energy[0];
            res_data_reg.energy1    <= lane_energy[1];
            res_data_reg.energy2    <= lane_energy[2];
            res_data_reg.out_row    <= 12'(s2_reg.orow);
            res_data_reg.out_col    <= 11'(s2_reg.ocol);
            res_data_reg.frame_last <= s2_reg.last;
        end
    end

    // ---------------- assertions ----------------
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit && frame_end) |=>
            (in_col_reg == '0 && in_row_reg == IN_ROW_FIRST
             && ocol_reg == '0 && orow_reg == '0))
        else $error("counters not back at frame start after the last result");

    a_orow_bound: assert property (@(posedge clk) disable iff (!rst_n)
        HGT_W'(orow_reg) < HGT_W'(MAX_HEIGHT))
        else $error("output row counter beyond the maximum height");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_reg.emit && !s2_free) |=>
            (s1_valid_reg && $stable(s1_reg)))
        else $error("blocked item left the line store stage");

endmodule

// ===== tb/neighbor_contrast_3x3_top_tb.sv =====
// Self-checking testbench for the 3x3 neighbor contrast filter top level.
`timescale 1ns / 1ps

module neighbor_contrast_3x3_top_tb;
    import ncon_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 150;
    localparam int LIMIT_NS      = 10_000_000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        pix_valid = 1'b0;
    logic        pix_stall;
    pix_item_t   pix_data  = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    res_item_t   res_data;

    // stimulus shaping
    int          send_gap_pct   = 0;
    int          recv_stall_pct = 0;
    logic        rx_hold        = 1'b0;
    int unsigned items_sent     = 0;
    int          error_count    = 0;

    // contrast predictor state
    pix_t        above_store  [DEF_MAX_WIDTH];
    pix_t        center_store [DEF_MAX_WIDTH];
    pix_t        win [9];   // index = column * 3 + row; column 2 newest, row 0 top
    logic [11:0] width_reg;
    logic [12:0] height_reg;
    int unsigned in_row;
    int unsigned in_col;
    int unsigned out_row;
    int unsigned out_col;
    res_item_t   contrast_due [$];

    neighbor_contrast_3x3_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int unsigned active_width();
        return clamp_size(width_reg, DEF_MAX_WIDTH);
    endfunction

    function automatic int unsigned active_height();
        return clamp_size(height_reg, DEF_MAX_HEIGHT);
    endfunction

    function automatic void reset_predictor();
        for (int i = 0; i < DEF_MAX_WIDTH; i++)
        begin
            above_store[i]  = '0;
            center_store[i] = '0;
        end
        for (int k = 0; k < 9; k++)
            win[k] = '0;
        width_reg  = FRAME_WIDTH_RST;
        height_reg = FRAME_HEIGHT_RST;
        in_row     = 0;
        in_col     = 0;
        out_row    = 0;
        out_col    = 0;
    endfunction

    // Largest nibble difference between the center and its neighbors, per channel.
    function automatic logic [2:0][7:0] window_energy(int lc, int cc, int rc, int tr, int br);
        int              col_sel [3];
        int              row_sel [3];
        int              v;
        int              n;
        int              d;
        int              best;
        logic [2:0][7:0] e;
        col_sel[0] = lc;
        col_sel[1] = cc;
        col_sel[2] = rc;
        row_sel[0] = tr;
        row_sel[1] = 1;
        row_sel[2] = br;
        for (int ch = 0; ch < 3; ch++)
        begin
            v    = win[cc * 3 + 1][ch];
            best = 0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    n = win[col_sel[i] * 3 + row_sel[j]][ch];
                    d = (n > v) ? n - v : v - n;
                    if (d > best)
                        best = d;
                end
            end
            e[ch] = 8'(best * 16);
        end
        return e;
    endfunction

    function automatic void predict_contrast(pix_item_t it);
        int unsigned     w;
        int unsigned     h;
        int unsigned     idx;
        int unsigned     orow;
        int unsigned     ocol;
        int              top;
        int              bot;
        bit              emit;
        bit              last;
        pix_t            px;
        logic [2:0][7:0] e;
        res_item_t       r;
        w    = active_width();
        h    = active_height();
        px   = {it.chan2[7:4], it.chan1[7:4], it.chan0[7:4]};
        if (it.cmd == CMD_FLUSH)
            px = '0;
        idx  = (in_col < DEF_MAX_WIDTH) ? in_col : DEF_MAX_WIDTH - 1;
        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        orow = out_row;
        ocol = out_col;
        top  = (orow == 0) ? 1 : 0;
        bot  = (orow + 1 >= h) ? 1 : 2;
        e    = '0;
        // the last column of a row finishes when the next row starts
        if (emit && in_col == 0)
            e = window_energy((ocol == 0) ? 2 : 1, 2, 2, top, bot);
        for (int k = 0; k < 6; k++)
            win[k] = win[k + 3];
        win[6] = above_store[idx];
        win[7] = center_store[idx];
        win[8] = px;
        above_store[idx]  = win[7];
        center_store[idx] = px;
        if (emit && in_col != 0)
            e = window_energy((ocol == 0) ? 1 : 0, 1, (ocol + 1 >= w) ? 1 : 2, top, bot);
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            if (in_row < 32'h00FF_FFFF)
                in_row++;
        end
        if (!emit)
            return;
        last         = (orow + 1 >= h) && (ocol + 1 >= w);
        r.energy0    = e[0];
        r.energy1    = e[1];
        r.energy2    = e[2];
        r.out_row    = orow[11:0];
        r.out_col    = ocol[10:0];
        r.frame_last = last;
        contrast_due = {contrast_due, r};
        out_col++;
        if (out_col >= w)
        begin
            out_col = 0;
            if (out_row < 32'h00FF_FFFF)
                out_row++;
        end
        if (last)
        begin
            in_row  = 0;
            in_col  = 0;
            out_row = 0;
            out_col = 0;
        end
    endfunction

    function automatic void check_result(res_item_t got);
        res_item_t want;
        if (contrast_due.size() == 0)
        begin
            error_count++;
            if (error_count <= 10)
                $display("unexpected result: %0d %0d %0d row %0d col %0d last %0b",
                         got.energy0, got.energy1, got.energy2,
                         got.out_row, got.out_col, got.frame_last);
            return;
        end
        want = contrast_due.pop_front();
        if (got.energy0 !== want.energy0 || got.energy1 !== want.energy1 ||
            got.energy2 !== want.energy2 || got.out_row !== want.out_row ||
            got.out_col !== want.out_col || got.frame_last !== want.frame_last)
        begin
            error_count++;
            if (error_count <= 10)
                $display({"result mismatch: expected %0d %0d %0d row %0d col %0d last %0b,",
                          " got %0d %0d %0d row %0d col %0d last %0b"},
                         want.energy0, want.energy1, want.energy2,
                         want.out_row, want.out_col, want.frame_last,
                         got.energy0, got.energy1, got.energy2,
                         got.out_row, got.out_col, got.frame_last);
        end
    endfunction

    // Output side: take results and decide the next stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else
        begin
            if (res_valid && !res_stall)
                check_result(res_data);
            res_stall <= rx_hold || ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    function automatic pix_item_t make_item(logic cmd, logic [7:0] c0, logic [7:0] c1,
                                            logic [7:0] c2);
        pix_item_t it;
        it.cmd   = cmd;
        it.chan0 = c0;
        it.chan1 = c1;
        it.chan2 = c2;
        return it;
    endfunction

    function automatic pix_item_t random_item(logic cmd);
        return make_item(cmd, 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // Offer one item and hold it until taken; valid stays high on return.
    task automatic send_item(pix_item_t it);
        if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= it;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        predict_contrast(it);
        items_sent++;
    endtask

    task automatic wait_idle();
        pix_valid <= 1'b0;
        while (contrast_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic sel, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (sel == REG_FRAME_WIDTH)
            width_reg = value[11:0];
        else
            height_reg = value[12:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_reg(logic sel);
        logic [31:0] want;
        want    = (sel == REG_FRAME_WIDTH) ? {20'd0, width_reg} : {19'd0, height_reg};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {sel, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
        begin
            error_count++;
            if (error_count <= 10)
                $display("register %0d readback: expected %0d, got %0d", sel, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame(logic [31:0] w_raw, logic [31:0] h_raw);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, w_raw);
        write_reg(REG_FRAME_HEIGHT, h_raw);
        check_reg(REG_FRAME_WIDTH);
        check_reg(REG_FRAME_HEIGHT);
    endtask

    // One frame of pixels, then width+1 drain items.
    task automatic send_frame(int flush_pct, int noise_pct);
        int unsigned w;
        int unsigned h;
        w = active_width();
        h = active_height();
        repeat (w * h)
            send_item(random_item(($urandom_range(0, 99) < flush_pct) ? CMD_FLUSH : CMD_PIXEL));
        repeat (w + 1)
            send_item(random_item(($urandom_range(0, 99) < noise_pct) ? CMD_PIXEL : CMD_FLUSH));
    endtask

    // Drain until the frame counters are back at the start of a frame.
    task automatic close_frame();
        while (in_row != 0 || in_col != 0 || out_row != 0 || out_col != 0)
            send_item(random_item(CMD_FLUSH));
    endtask

    task automatic test_register_access();
        check_reg(REG_FRAME_WIDTH);
        check_reg(REG_FRAME_HEIGHT);
        set_frame(32'd0, 32'd0);
        set_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        set_frame(32'd2048, 32'd4096);
    endtask

    task automatic test_directed_frame();
        set_frame(32'd3, 32'd2);
        send_item(make_item(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_item(CMD_PIXEL, 8'h00, 8'h00, 8'h00));
        send_item(make_item(CMD_PIXEL, 8'h0F, 8'hF0, 8'h80));
        // flush inside the frame counts as a black pixel
        send_item(make_item(CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_item(CMD_PIXEL, 8'hF0, 8'h0F, 8'h7F));
        send_item(make_item(CMD_PIXEL, 8'h10, 8'hE0, 8'h31));
        // drain, with a stray pixel among the flush items
        send_item(make_item(CMD_FLUSH, 8'h00, 8'h00, 8'h00));
        send_item(make_item(CMD_PIXEL, 8'hAA, 8'h55, 8'hFF));
        send_item(make_item(CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_item(CMD_FLUSH, 8'h12, 8'h34, 8'h56));
        // items after the frame start the next one
        send_item(make_item(CMD_PIXEL, 8'h80, 8'h80, 8'h80));
        send_item(make_item(CMD_PIXEL, 8'h7F, 8'h7F, 8'h7F));
        close_frame();
        wait_idle();
    endtask

    task automatic test_size_extremes();
        // zero size acts as a single pixel
        set_frame(32'd0, 32'd0);
        send_frame(5, 5);
        set_frame(32'h0000_F000, 32'hFFFF_E000);
        send_frame(5, 5);
        // oversized height: run a few rows, then shrink so the frame ends
        set_frame(32'd4, 32'hFFFF_FFFF);
        repeat (14) send_item(random_item(CMD_PIXEL));
        wait_idle();
        write_reg(REG_FRAME_HEIGHT, 32'd0);
        check_reg(REG_FRAME_HEIGHT);
        close_frame();
        wait_idle();
        // oversized width: a few items, then shrink so the columns wrap
        set_frame(32'hFFFF_FFFF, 32'd2);
        repeat (9) send_item(random_item(CMD_PIXEL));
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 32'd3);
        check_reg(REG_FRAME_WIDTH);
        close_frame();
        wait_idle();
    endtask

    task automatic test_output_holdoff();
        set_frame(32'd16, 32'd6);
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
            send_frame(0, 0);
        join
        wait_idle();
    endtask

    task automatic test_sender_pause();
        set_frame(32'd5, 32'd4);
        repeat (12) send_item(random_item(CMD_PIXEL));
        wait_idle();
        repeat (8) send_item(random_item(CMD_PIXEL));
        close_frame();
        wait_idle();
    endtask

    task automatic test_resize_mid_frame();
        set_frame(32'd6, 32'd4);
        send_frame(5, 5);
        // stop past the new width so both column counters wrap
        repeat (17) send_item(random_item(CMD_PIXEL));
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 32'd3);
        check_reg(REG_FRAME_WIDTH);
        repeat (4) send_item(random_item(CMD_PIXEL));
        wait_idle();
        write_reg(REG_FRAME_HEIGHT, 32'd1);
        check_reg(REG_FRAME_HEIGHT);
        close_frame();
        wait_idle();
    endtask

    task automatic test_random_frames(int unsigned budget);
        int unsigned start;
        int unsigned w;
        int unsigned h;
        bit          first;
        start = items_sent;
        first = 1'b1;
        while (items_sent - start < budget)
        begin
            if (first || $urandom_range(0, 1) == 0)
            begin
                close_frame();
                w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
                h = $urandom_range(0, 5);
                set_frame(($urandom & 32'hFFFF_F000) | w, ($urandom & 32'hFFFF_E000) | h);
                first = 1'b0;
            end
            if ($urandom_range(0, 99) < 85)
                send_frame(10, 20);
            else
                repeat ($urandom_range(1, active_width() * active_height() + active_width()))
                    send_item(random_item(1'($urandom_range(0, 1))));
        end
        close_frame();
        wait_idle();
    endtask

    initial
    begin
        reset_predictor();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct   = 34;
        recv_stall_pct <= 59;
        test_register_access();
        test_directed_frame();
        test_random_frames(45);

        send_gap_pct   = 59;
        recv_stall_pct <= 34;
        test_output_holdoff();
        test_sender_pause();
        test_resize_mid_frame();
        test_random_frames(45);

        send_gap_pct   = 0;
        recv_stall_pct <= 0;
        test_size_extremes();
        test_random_frames(45);

        wait_idle();
        repeat (20) @(posedge clk);
        if (contrast_due.size() != 0)
        begin
            error_count += contrast_due.size();
            $display("results never received: %0d", contrast_due.size());
        end
        if (error_count == 0)
            $display("neighbor_contrast_3x3_top regression: pass");
        else
            $display("neighbor_contrast_3x3_top regression: fail");
        $finish;
    end

    initial
    begin
        #LIMIT_NS;
        $display("neighbor_contrast_3x3_top regression: fail");
        $finish;
    end

endmodule
